@@ sv/btd_pkg.sv @@
// Shared constants and types for the box-to-target distance estimator.
`timescale 1ns / 1ps

package btd_pkg;

    localparam int OP_W       = 2;
    localparam int IN_COORD_W = 8;
    localparam int DIST_W     = 13;

    localparam logic [OP_W-1:0] OP_LOAD_TARGET = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_BOX    = 2'd1;
    localparam logic [OP_W-1:0] OP_EVALUATE    = 2'd2;

    localparam logic [DIST_W-1:0] DIST_MAX = 13'd8191;

    localparam int DEF_MAX_BOXES   = 16;
    localparam int DEF_MAX_TARGETS = 16;
    localparam int DEF_COORD_BITS  = 8;

    // Write and read strobes from the sequencer to the position stores.
    typedef struct packed {
        logic wr_target;
        logic wr_box;
        logic rd;
    } store_cmd_t;

endpackage

@@ sv/btd_store.sv @@
// Box and target position memories with one write port and a registered read each.
`timescale 1ns / 1ps

module btd_store #(
    parameter int MAX_BOXES   = btd_pkg::DEF_MAX_BOXES,
    parameter int MAX_TARGETS = btd_pkg::DEF_MAX_TARGETS,
    parameter int COORD_BITS  = btd_pkg::DEF_COORD_BITS,
    parameter int BIW         = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
    parameter int TIW         = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1
) (
    input  logic                            clk,
    input  btd_pkg::store_cmd_t             cmd,
    input  logic [btd_pkg::IN_COORD_W-1:0]  x_coord,
    input  logic [btd_pkg::IN_COORD_W-1:0]  y_coord,
    input  logic [TIW-1:0]                  tgt_waddr,
    input  logic [BIW-1:0]                  box_waddr,
    input  logic [TIW-1:0]                  tgt_raddr,
    input  logic [BIW-1:0]                  box_raddr,
    output logic [COORD_BITS-1:0]           box_x,
    output logic [COORD_BITS-1:0]           box_y,
    output logic [COORD_BITS-1:0]           tgt_x,
    output logic [COORD_BITS-1:0]           tgt_y
);
    import btd_pkg::*;

    logic [2*COORD_BITS-1:0] box_mem [MAX_BOXES];
    logic [2*COORD_BITS-1:0] tgt_mem [MAX_TARGETS];
    logic [COORD_BITS-1:0]   cx;
    logic [COORD_BITS-1:0]   cy;

    // Coordinates are masked or widened to the stored width.
    assign cx = COORD_BITS'(x_coord);
    assign cy = COORD_BITS'(y_coord);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_box)
        begin
            box_mem[box_waddr] <= {cx, cy};
        end
        if (cmd.rd)
        begin
            {box_x, box_y} <= box_mem[box_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_target)
        begin
            tgt_mem[tgt_waddr] <= {cx, cy};
        end
        if (cmd.rd)
        begin
            {tgt_x, tgt_y} <= tgt_mem[tgt_raddr];
        end
    end

endmodule

@@ sv/btd_dist.sv @@
// Shared Manhattan distance unit: one box/target pair per cycle, registered result.
`timescale 1ns / 1ps

module btd_dist #(
    parameter int COORD_BITS = btd_pkg::DEF_COORD_BITS
) (
    input  logic                  clk,
    input  logic [COORD_BITS-1:0] box_x,
    input  logic [COORD_BITS-1:0] box_y,
    input  logic [COORD_BITS-1:0] tgt_x,
    input  logic [COORD_BITS-1:0] tgt_y,
    output logic [COORD_BITS:0]   pair_dist
);
    import btd_pkg::*;

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS:0]   dist_next;

    assign dx = (box_x > tgt_x) ? (box_x - tgt_x) : (tgt_x - box_x);
    assign dy = (box_y > tgt_y) ? (box_y - tgt_y) : (tgt_y - box_y);
    assign dist_next = {1'b0, dx} + {1'b0, dy};

    always_ff @(posedge clk)
    begin
        pair_dist <= dist_next;
    end

endmodule

@@ sv/btd_seq.sv @@
// Sequencer: list counts, pair walk, nearest-target compare, accumulation and result register.
`timescale 1ns / 1ps

module btd_seq #(
    parameter int MAX_BOXES   = btd_pkg::DEF_MAX_BOXES,
    parameter int MAX_TARGETS = btd_pkg::DEF_MAX_TARGETS,
    parameter int COORD_BITS  = btd_pkg::DEF_COORD_BITS,
    parameter int BIW         = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
    parameter int TIW         = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [btd_pkg::OP_W-1:0]    operation,
    input  logic                        heuristic_mode,
    output btd_pkg::store_cmd_t         cmd,
    output logic [TIW-1:0]              tgt_waddr,
    output logic [BIW-1:0]              box_waddr,
    output logic [TIW-1:0]              tgt_raddr,
    output logic [BIW-1:0]              box_raddr,
    input  logic [COORD_BITS:0]         pair_dist,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [btd_pkg::DIST_W-1:0]  total_distance,
    output logic                        overflow
);
    import btd_pkg::*;

    localparam int BCW   = $clog2(MAX_BOXES + 1);
    localparam int TCW   = $clog2(MAX_TARGETS + 1);
    localparam int DW    = COORD_BITS + 1;
    localparam int SUM_W = ((DW > DIST_W) ? DW : DIST_W) + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [TCW-1:0]         tcount_reg, tcount_next;
    logic [BCW-1:0]         bcount_reg, bcount_next;
    logic                   dropped_reg, dropped_next;
    logic                   ovf_reg, ovf_next;
    logic                   issue_reg, issue_next;
    logic [BIW-1:0]         b_reg, b_next;
    logic [TIW-1:0]         t_reg, t_next;
    logic                   s1_valid_reg, s1_last_t_reg, s1_last_all_reg;
    logic [TIW-1:0]         s1_t_reg;
    logic                   s2_valid_reg, s2_last_t_reg, s2_last_all_reg;
    logic [TIW-1:0]         s2_t_reg;
    logic                   found_reg, found_next;
    logic [DW-1:0]          best_reg, best_next;
    logic [TIW-1:0]         best_idx_reg, best_idx_next;
    logic [MAX_TARGETS-1:0] used_reg, used_next;
    logic [DIST_W-1:0]      total_reg, total_next;
    logic                   res_valid_reg, res_valid_next;
    logic [DIST_W-1:0]      res_total_reg, res_total_next;
    logic                   res_ovf_reg, res_ovf_next;

    logic                   accept;
    logic                   last_t;
    logic                   last_b;
    logic                   cand_ok;
    logic                   take;
    logic                   nf;
    logic [DW-1:0]          nb;
    logic [TIW-1:0]         nidx;
    logic [SUM_W-1:0]       sum;
    logic [DIST_W-1:0]      sum_sat;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && (state_reg == ST_IDLE);

    assign last_t = (TCW'(t_reg) == (tcount_reg - TCW'(1)));
    assign last_b = (BCW'(b_reg) == (bcount_reg - BCW'(1)));

    assign tgt_waddr = tcount_reg[TIW-1:0];
    assign box_waddr = bcount_reg[BIW-1:0];
    assign tgt_raddr = t_reg;
    assign box_raddr = b_reg;

    // Compare stage: in greedy mode a target already taken by an earlier box is skipped.
    assign cand_ok = s2_valid_reg && !(heuristic_mode && used_reg[s2_t_reg]);
    assign take    = cand_ok && (!found_reg || (pair_dist < best_reg));
    assign nf      = found_reg || take;
    assign nb      = take ? pair_dist : best_reg;
    assign nidx    = take ? s2_t_reg : best_idx_reg;
    assign sum     = SUM_W'(total_reg) + SUM_W'(nb);
    assign sum_sat = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        tcount_next    = tcount_reg;
        bcount_next    = bcount_reg;
        dropped_next   = dropped_reg;
        ovf_next       = ovf_reg;
        issue_next     = issue_reg;
        b_next         = b_reg;
        t_next         = t_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        used_next      = used_reg;
        total_next     = total_reg;
        res_valid_next = res_valid_reg;
        res_total_next = res_total_reg;
        res_ovf_next   = res_ovf_reg;
        cmd            = '0;

        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (operation == OP_LOAD_TARGET)
                    begin
                        if (tcount_reg == TCW'(MAX_TARGETS))
                        begin
                            dropped_next = 1'b1;
                        end
                        else
                        begin
                            cmd.wr_target = 1'b1;
                            tcount_next   = tcount_reg + TCW'(1);
                        end
                    end
                    else if (operation == OP_LOAD_BOX)
                    begin
                        if (bcount_reg == BCW'(MAX_BOXES))
                        begin
                            dropped_next = 1'b1;
                        end
                        else
                        begin
                            cmd.wr_box  = 1'b1;
                            bcount_next = bcount_reg + BCW'(1);
                        end
                    end
                    else if (operation == OP_EVALUATE)
                    begin
                        ovf_next     = dropped_reg;
                        dropped_next = 1'b0;
                        total_next   = '0;
                        used_next    = '0;
                        found_next   = 1'b0;
                        b_next       = '0;
                        t_next       = '0;
                        if ((tcount_reg == '0) || (bcount_reg == '0))
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            issue_next = 1'b1;
                            state_next = ST_RUN;
                        end
                    end
                    else
                    begin
                        // The unused operation code is dropped without effect.
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_RUN:
            begin
                if (issue_reg)
                begin
                    cmd.rd = 1'b1;
                    if (last_t)
                    begin
                        t_next = '0;
                        if (last_b)
                        begin
                            issue_next = 1'b0;
                        end
                        else
                        begin
                            b_next = b_reg + BIW'(1);
                        end
                    end
                    else
                    begin
                        t_next = t_reg + TIW'(1);
                    end
                end

                if (s2_valid_reg)
                begin
                    if (s2_last_t_reg)
                    begin
                        found_next = 1'b0;
                        if (nf)
                        begin
                            total_next = sum_sat;
                            if (heuristic_mode)
                            begin
                                used_next = used_reg | (MAX_TARGETS'(1) << nidx);
                            end
                        end
                    end
                    else
                    begin
                        found_next    = nf;
                        best_next     = nb;
                        best_idx_next = nidx;
                    end
                    if (s2_last_all_reg)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_valid_next = 1'b1;
                    res_total_next = total_reg;
                    res_ovf_next   = ovf_reg;
                    tcount_next    = '0;
                    bcount_next    = '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            tcount_reg      <= '0;
            bcount_reg      <= '0;
            dropped_reg     <= 1'b0;
            ovf_reg         <= 1'b0;
            issue_reg       <= 1'b0;
            b_reg           <= '0;
            t_reg           <= '0;
            s1_valid_reg    <= 1'b0;
            s1_last_t_reg   <= 1'b0;
            s1_last_all_reg <= 1'b0;
            s1_t_reg        <= '0;
            s2_valid_reg    <= 1'b0;
            s2_last_t_reg   <= 1'b0;
            s2_last_all_reg <= 1'b0;
            s2_t_reg        <= '0;
            found_reg       <= 1'b0;
            used_reg        <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            tcount_reg      <= tcount_next;
            bcount_reg      <= bcount_next;
            dropped_reg     <= dropped_next;
            ovf_reg         <= ovf_next;
            issue_reg       <= issue_next;
            b_reg           <= b_next;
            t_reg           <= t_next;
            // Tags follow each pair through the memory read and the distance register.
            s1_valid_reg    <= (state_reg == ST_RUN) && issue_reg;
            s1_last_t_reg   <= last_t;
            s1_last_all_reg <= last_t && last_b;
            s1_t_reg        <= t_reg;
            s2_valid_reg    <= s1_valid_reg;
            s2_last_t_reg   <= s1_last_t_reg;
            s2_last_all_reg <= s1_last_all_reg;
            s2_t_reg        <= s1_t_reg;
            found_reg       <= found_next;
            used_reg        <= used_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        total_reg     <= total_next;
        res_total_reg <= res_total_next;
        res_ovf_reg   <= res_ovf_next;
    end

    assign result_valid   = res_valid_reg;
    assign total_distance = res_total_reg;
    assign overflow       = res_ovf_reg;

endmodule

@@ sv/box_target_distance_heuristic_top.sv @@
// Top level of the box-to-target distance estimator.
//
// Items arrive on the item channel (item_valid / item_stall) with operation,
// x_coord and y_coord. A load target or load box beat keeps the block idle
// and gives no result; a load into a full list is dropped and remembered.
// An evaluate beat walks every box/target pair through one shared distance
// unit, one pair per cycle, and the item channel stalls until the estimate
// is placed in the output register. Each pair passes the memory read and the
// distance register to the compare stage; an empty list skips the pair walk.
// Results leave on the result channel (result_valid / result_stall). While
// the receiver stalls, the result is held and loads are still taken; a
// following evaluate waits in its last step until the register is free.
// The mode register must be written with cfg_wr_en / cfg_wr_data only while
// idle by the user; the block does not enforce it. Reset empties both lists,
// clears the dropped flag, mode and result valid.
`timescale 1ns / 1ps

module box_target_distance_heuristic_top #(
    parameter int MAX_BOXES   = btd_pkg::DEF_MAX_BOXES,
    parameter int MAX_TARGETS = btd_pkg::DEF_MAX_TARGETS,
    parameter int COORD_BITS  = btd_pkg::DEF_COORD_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic [btd_pkg::OP_W-1:0]        operation,
    input  logic [btd_pkg::IN_COORD_W-1:0]  x_coord,
    input  logic [btd_pkg::IN_COORD_W-1:0]  y_coord,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [btd_pkg::DIST_W-1:0]      total_distance,
    output logic                            overflow
);
    import btd_pkg::*;

    localparam int BIW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int TIW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;

    logic                  mode_reg;
    store_cmd_t            cmd;
    logic [TIW-1:0]        tgt_waddr;
    logic [BIW-1:0]        box_waddr;
    logic [TIW-1:0]        tgt_raddr;
    logic [BIW-1:0]        box_raddr;
    logic [COORD_BITS-1:0] box_x;
    logic [COORD_BITS-1:0] box_y;
    logic [COORD_BITS-1:0] tgt_x;
    logic [COORD_BITS-1:0] tgt_y;
    logic [COORD_BITS:0]   pair_dist;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= cfg_wr_data;
        end
    end

    btd_store #(
        .MAX_BOXES   (MAX_BOXES),
        .MAX_TARGETS (MAX_TARGETS),
        .COORD_BITS  (COORD_BITS),
        .BIW         (BIW),
        .TIW         (TIW)
    ) u_store (
        .clk       (clk),
        .cmd       (cmd),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .tgt_waddr (tgt_waddr),
        .box_waddr (box_waddr),
        .tgt_raddr (tgt_raddr),
        .box_raddr (box_raddr),
        .box_x     (box_x),
        .box_y     (box_y),
        .tgt_x     (tgt_x),
        .tgt_y     (tgt_y)
    );

    btd_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk       (clk),
        .box_x     (box_x),
        .box_y     (box_y),
        .tgt_x     (tgt_x),
        .tgt_y     (tgt_y),
        .pair_dist (pair_dist)
    );

    btd_seq #(
        .MAX_BOXES   (MAX_BOXES),
        .MAX_TARGETS (MAX_TARGETS),
        .COORD_BITS  (COORD_BITS),
        .BIW         (BIW),
        .TIW         (TIW)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .operation      (operation),
        .heuristic_mode (mode_reg),
        .cmd            (cmd),
        .tgt_waddr      (tgt_waddr),
        .box_waddr      (box_waddr),
        .tgt_raddr      (tgt_raddr),
        .box_raddr      (box_raddr),
        .pair_dist      (pair_dist),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .total_distance (total_distance),
        .overflow       (overflow)
    );

endmodule

@@ sv/btd_checker.sv @@
// Port-level checker for the distance estimator and its bind to the top level.
`timescale 1ns / 1ps

module btd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_stall,
    input logic [btd_pkg::OP_W-1:0]     operation,
    input logic                         result_valid,
    input logic                         result_stall,
    input logic [btd_pkg::DIST_W-1:0]   total_distance,
    input logic                         overflow
);
    import btd_pkg::*;

    // An accepted evaluate always leaves the block busy, with the item channel stalled.
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && (operation == OP_EVALUATE)) |=> item_stall)
        else $error("item channel open right after an evaluate beat");

    // A load beat never produces a result.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall &&
         ((operation == OP_LOAD_TARGET) || (operation == OP_LOAD_BOX)))
        |=> !$rose(result_valid))
        else $error("result appeared after a load beat");

    // A new result only comes out of an evaluation that held the item channel.
    a_result_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result rose while the block was idle");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
        (result_valid && $stable(total_distance) && $stable(overflow)))
        else $error("stalled result beat changed");

endmodule

bind box_target_distance_heuristic_top btd_checker u_btd_checker (.*);

@@ bench/btd_estimate_checker.sv @@
// Checker that follows the item, result and mode beats and compares every distance estimate.
`timescale 1ns / 1ps

module btd_estimate_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    input  logic                            item_valid,
    input  logic                            item_stall,
    input  logic [btd_pkg::OP_W-1:0]        operation,
    input  logic [btd_pkg::IN_COORD_W-1:0]  x_coord,
    input  logic [btd_pkg::IN_COORD_W-1:0]  y_coord,
    input  logic                            result_valid,
    input  logic                            result_stall,
    input  logic [btd_pkg::DIST_W-1:0]      total_distance,
    input  logic                            overflow,
    output int                              fail_count,
    output int                              pending
);
    import btd_pkg::*;

    localparam int NUM_BOXES   = DEF_MAX_BOXES;
    localparam int NUM_TARGETS = DEF_MAX_TARGETS;
    localparam logic [IN_COORD_W-1:0] COORD_MASK = IN_COORD_W'((1 << DEF_COORD_BITS) - 1);
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [DIST_W-1:0] est_total;
        logic              ovf;
    } estimate_t;

    estimate_t expected_estimates[$];
    estimate_t fresh;
    estimate_t oldest;

    logic [IN_COORD_W-1:0] box_x [NUM_BOXES];
    logic [IN_COORD_W-1:0] box_y [NUM_BOXES];
    logic [IN_COORD_W-1:0] tgt_x [NUM_TARGETS];
    logic [IN_COORD_W-1:0] tgt_y [NUM_TARGETS];
    int   box_n;
    int   tgt_n;
    logic dropped = 1'b0;
    logic greedy_mode = 1'b0;

    int mismatch_count = 0;
    int queued = 0;

    assign fail_count = mismatch_count;
    assign pending    = queued;

    function automatic int coord_gap(input logic [IN_COORD_W-1:0] a,
                                     input logic [IN_COORD_W-1:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // Sum of box distances; in greedy mode each target serves one box at most.
    function automatic logic [DIST_W-1:0] estimate_distance();
        int                     total;
        int                     best;
        int                     best_idx;
        int                     d;
        logic                   found;
        logic [NUM_TARGETS-1:0] taken;
        total = 0;
        taken = '0;
        if (box_n == 0 || tgt_n == 0)
        begin
            return '0;
        end
        for (int b = 0; b < box_n; b++)
        begin
            found    = 1'b0;
            best     = 0;
            best_idx = 0;
            for (int t = 0; t < tgt_n; t++)
            begin
                if (!(greedy_mode && taken[t]))
                begin
                    d = coord_gap(box_x[b], tgt_x[t]) + coord_gap(box_y[b], tgt_y[t]);
                    // Strict compare keeps the lowest index on a tie.
                    if (!found || d < best)
                    begin
                        found    = 1'b1;
                        best     = d;
                        best_idx = t;
                    end
                end
            end
            if (found)
            begin
                if (greedy_mode)
                begin
                    taken[best_idx] = 1'b1;
                end
                total += best;
                if (total > int'(DIST_MAX))
                begin
                    total = int'(DIST_MAX);
                end
            end
        end
        return total[DIST_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_n       = 0;
            tgt_n       = 0;
            dropped     = 1'b0;
            greedy_mode = 1'b0;
            expected_estimates.delete();
            queued      = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                greedy_mode = cfg_wr_data;
            end
            if (item_valid && !item_stall)
            begin
                case (operation)
                    OP_LOAD_TARGET:
                    begin
                        if (tgt_n < NUM_TARGETS)
                        begin
                            tgt_x[tgt_n] = x_coord & COORD_MASK;
                            tgt_y[tgt_n] = y_coord & COORD_MASK;
                            tgt_n++;
                        end
                        else
                        begin
                            dropped = 1'b1;
                        end
                    end
                    OP_LOAD_BOX:
                    begin
                        if (box_n < NUM_BOXES)
                        begin
                            box_x[box_n] = x_coord & COORD_MASK;
                            box_y[box_n] = y_coord & COORD_MASK;
                            box_n++;
                        end
                        else
                        begin
                            dropped = 1'b1;
                        end
                    end
                    OP_EVALUATE:
                    begin
                        fresh.est_total = estimate_distance();
                        fresh.ovf       = dropped;
                        expected_estimates = {expected_estimates, fresh};
                        box_n   = 0;
                        tgt_n   = 0;
                        dropped = 1'b0;
                    end
                    default:
                    begin
                        // The unused operation code leaves everything as it was.
                    end
                endcase
            end
            if (result_valid && !result_stall)
            begin
                if (expected_estimates.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: unexpected result beat: distance %0d overflow %0d",
                                 $realtime, total_distance, overflow);
                    end
                end
                else
                begin
                    oldest = expected_estimates.pop_front();
                    if (oldest.est_total !== total_distance || oldest.ovf !== overflow)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: distance exp %0d got %0d, overflow exp %0d got %0d",
                                     $realtime, oldest.est_total, total_distance,
                                     oldest.ovf, overflow);
                        end
                    end
                end
            end
            queued = expected_estimates.size();
        end
    end

endmodule

@@ bench/box_target_distance_heuristic_top_test.sv @@
// Stimulus, clock, reset and verdict for the box-to-target distance estimator.
`timescale 1ns / 1ps

module box_target_distance_heuristic_top_test;
    import btd_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int LIMIT        = 400000;
    // Longest evaluate walks 16 x 16 pairs.
    localparam int SETTLE       = 300;
    localparam int RANDOM_ITEMS = 450;
    localparam int MIN_EVALS    = 20;
    localparam int MAX_GAP      = 18;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic                  cfg_wr_data;
    logic                  item_valid;
    logic                  item_stall;
    logic [OP_W-1:0]       operation;
    logic [IN_COORD_W-1:0] x_coord;
    logic [IN_COORD_W-1:0] y_coord;
    logic                  result_valid;
    logic                  result_stall;
    logic [DIST_W-1:0]     total_distance;
    logic                  overflow;

    int fail_count;
    int pending;
    int cycles     = 0;
    int items_sent = 0;
    int evals_sent = 0;
    bit tx_burst   = 1'b0;
    bit rx_burst   = 1'b0;

    box_target_distance_heuristic_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .operation      (operation),
        .x_coord        (x_coord),
        .y_coord        (y_coord),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .total_distance (total_distance),
        .overflow       (overflow)
    );

    btd_estimate_checker estimate_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .operation      (operation),
        .x_coord        (x_coord),
        .y_coord        (y_coord),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .total_distance (total_distance),
        .overflow       (overflow),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_item(input logic [OP_W-1:0] op,
                             input logic [IN_COORD_W-1:0] x,
                             input logic [IN_COORD_W-1:0] y);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid = 1'b1;
        operation  = op;
        x_coord    = x;
        y_coord    = y;
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
        if (op != OP_UNUSED)
        begin
            items_sent++;
        end
        if (op == OP_EVALUATE)
        begin
            evals_sent++;
        end
    endtask

    // Holds the sender until every estimate has come back and the block is quiet.
    task automatic drain_results();
        item_valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = m;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    function automatic logic [IN_COORD_W-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
        begin
            return '0;
        end
        if (r == 1)
        begin
            return '1;
        end
        return IN_COORD_W'($urandom_range(0, 255));
    endfunction

    // Mostly short lists, some near capacity, a few past it.
    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
        begin
            return $urandom_range(0, 6);
        end
        if (r < 9)
        begin
            return $urandom_range(7, 16);
        end
        return $urandom_range(17, 20);
    endfunction

    task automatic run_sequence();
        int nt;
        int nb;
        nt = pick_count();
        nb = pick_count();
        tx_burst = ($urandom_range(0, 3) == 0);
        while (nt + nb > 0)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                send_item(OP_UNUSED, IN_COORD_W'($urandom_range(0, 255)),
                          IN_COORD_W'($urandom_range(0, 255)));
            end
            if (nb == 0 || (nt > 0 && $urandom_range(0, 1) == 0))
            begin
                send_item(OP_LOAD_TARGET, pick_coord(), pick_coord());
                nt--;
            end
            else
            begin
                send_item(OP_LOAD_BOX, pick_coord(), pick_coord());
                nb--;
            end
        end
        // Now and then the evaluate is left out and the loads carry into the next sequence.
        if ($urandom_range(0, 7) != 0)
        begin
            send_item(OP_EVALUATE, IN_COORD_W'($urandom_range(0, 255)),
                      IN_COORD_W'($urandom_range(0, 255)));
        end
    endtask

    // Receiver: stalls for a random gap before each result beat, with no stall in a burst.
    initial
    begin
        int w;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                rx_burst = ~rx_burst;
            end
            w = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (w > 0)
            begin
                @(negedge clk);
                result_stall = 1'b1;
                repeat (w - 1) @(negedge clk);
            end
            @(negedge clk);
            result_stall = 1'b0;
            do
                @(posedge clk);
            while (!result_valid);
        end
    end

    initial
    begin
        int ph;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        item_valid  = 1'b0;
        operation   = OP_LOAD_TARGET;
        x_coord     = '0;
        y_coord     = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Nearest-target mode straight out of reset.
        send_item(OP_EVALUATE, 8'd0, 8'd0);
        send_item(OP_LOAD_TARGET, 8'd255, 8'd0);
        send_item(OP_EVALUATE, 8'd255, 8'd255);
        send_item(OP_LOAD_BOX, 8'd0, 8'd255);
        send_item(OP_EVALUATE, 8'd0, 8'd0);
        send_item(OP_LOAD_TARGET, 8'd0, 8'd0);
        send_item(OP_LOAD_BOX, 8'd255, 8'd255);
        send_item(OP_EVALUATE, 8'd0, 8'd0);
        send_item(OP_UNUSED, 8'd7, 8'd9);
        send_item(OP_LOAD_TARGET, 8'd10, 8'd10);
        send_item(OP_LOAD_TARGET, 8'd20, 8'd20);
        send_item(OP_LOAD_BOX, 8'd15, 8'd15);
        send_item(OP_LOAD_BOX, 8'd15, 8'd15);
        send_item(OP_EVALUATE, 8'd0, 8'd0);
        drain_results();

        // Greedy mode: ties, a box left without a target, and a forced far pick.
        write_mode(1'b1);
        send_item(OP_LOAD_TARGET, 8'd10, 8'd10);
        send_item(OP_LOAD_TARGET, 8'd20, 8'd20);
        send_item(OP_LOAD_BOX, 8'd15, 8'd15);
        send_item(OP_LOAD_BOX, 8'd15, 8'd15);
        send_item(OP_LOAD_BOX, 8'd15, 8'd15);
        send_item(OP_EVALUATE, 8'd0, 8'd0);
        send_item(OP_LOAD_TARGET, 8'd0, 8'd0);
        send_item(OP_LOAD_TARGET, 8'd100, 8'd0);
        send_item(OP_LOAD_BOX, 8'd1, 8'd0);
        send_item(OP_LOAD_BOX, 8'd0, 8'd0);
        send_item(OP_EVALUATE, 8'd0, 8'd0);

        items_sent = 0;
        evals_sent = 0;
        ph = 0;
        while (items_sent < RANDOM_ITEMS || evals_sent < MIN_EVALS)
        begin
            drain_results();
            write_mode((ph % 3 == 2) ? 1'($urandom_range(0, 1)) : 1'(ph % 2));
            repeat (6) run_sequence();
            ph++;
        end

        drain_results();
        if (fail_count == 0 && pending == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
